@@ sv/mes_pkg.sv @@
`timescale 1ns / 1ps
// Package for the markup escape stream: job type, register indexes, character codes
// and the escape sequence tables. Used by every module of the block; depends on nothing.
package mes_pkg;

	localparam int unsigned REG_IDX_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_MARKUP_EN    = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_TAG_OPEN     = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_TAG_CLOSE    = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_ENTITY_START = 2'd3;

	localparam logic [7:0] RST_TAG_OPEN     = 8'd3;
	localparam logic [7:0] RST_TAG_CLOSE    = 8'd4;
	localparam logic [7:0] RST_ENTITY_START = 8'd6;

	localparam logic [7:0] CH_LT   = 8'h3C;
	localparam logic [7:0] CH_GT   = 8'h3E;
	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_QUOT = 8'h22;
	localparam logic [7:0] CH_SEMI = 8'h3B;

	localparam int unsigned ESC_MAX = 6;
	localparam int unsigned ESC_IDX_W = 3;

	localparam logic [7:0] ESC_LT_SEQ [0:ESC_MAX-1] =
		'{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00};
	localparam logic [7:0] ESC_GT_SEQ [0:ESC_MAX-1] =
		'{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00};
	localparam logic [7:0] ESC_AMP_SEQ [0:ESC_MAX-1] =
		'{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00};
	localparam logic [7:0] ESC_QUOT_SEQ [0:ESC_MAX-1] =
		'{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B};

	// One unit of work for the back end: either a byte copied as it is, or a
	// special character that expands into its escape sequence.
	typedef struct packed {
		logic       esc;
		logic [7:0] ch;
	} job_t;

	function automatic logic [ESC_IDX_W-1:0] esc_last_idx(input logic [7:0] ch);
		logic [ESC_IDX_W-1:0] r;
		case (ch)
			CH_LT:   r = 3'd3;
			CH_GT:   r = 3'd3;
			CH_AMP:  r = 3'd4;
			CH_QUOT: r = 3'd5;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] esc_byte(input logic [7:0] ch,
			input logic [ESC_IDX_W-1:0] idx);
		logic [7:0] r;
		r = 8'h00;
		if (idx < ESC_IDX_W'(ESC_MAX)) begin
			case (ch)
				CH_LT:   r = ESC_LT_SEQ[idx];
				CH_GT:   r = ESC_GT_SEQ[idx];
				CH_AMP:  r = ESC_AMP_SEQ[idx];
				CH_QUOT: r = ESC_QUOT_SEQ[idx];
				default: r = ch;
			endcase
		end
		return r;
	endfunction

endpackage

@@ sv/mes_front.sv @@
`timescale 1ns / 1ps
// Front end: configuration registers, region flags and classification of each input beat
// into a job for the back end. Depends on mes_pkg.
module mes_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [7:0]                    in_byte,
	input  logic                          end_of_text,
	input  logic                          wr_en,
	input  logic [mes_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [7:0]                    wr_data,
	input  logic                          job_full,
	output logic                          job_push,
	output mes_pkg::job_t                 job
);

	logic       markup_en_q;
	logic [7:0] tag_open_q;
	logic [7:0] tag_close_q;
	logic [7:0] entity_start_q;
	logic       inside_tag_q;
	logic       inside_entity_q;

	logic accept;
	logic emit;
	logic tag_d;
	logic entity_d;

	assign full   = job_full;
	assign accept = push && !job_full;

	always_comb begin
		emit     = 1'b0;
		job.esc  = 1'b0;
		job.ch   = in_byte;
		tag_d    = inside_tag_q;
		entity_d = inside_entity_q;
		if (inside_tag_q) begin
			emit = markup_en_q;
			if (in_byte == tag_close_q) begin
				tag_d  = 1'b0;
				job.ch = mes_pkg::CH_GT;
			end
		end else if (inside_entity_q) begin
			emit = markup_en_q;
			if (in_byte == mes_pkg::CH_SEMI) begin
				entity_d = 1'b0;
			end
		end else if (in_byte == tag_open_q) begin
			tag_d  = 1'b1;
			emit   = markup_en_q;
			job.ch = mes_pkg::CH_LT;
		end else if (in_byte == tag_close_q) begin
			emit   = markup_en_q;
			job.ch = mes_pkg::CH_GT;
		end else if (in_byte == entity_start_q) begin
			entity_d = 1'b1;
			emit     = markup_en_q;
			job.ch   = mes_pkg::CH_AMP;
		end else begin
			emit    = 1'b1;
			job.esc = markup_en_q && (in_byte inside {mes_pkg::CH_LT, mes_pkg::CH_GT,
				mes_pkg::CH_AMP, mes_pkg::CH_QUOT});
		end
	end

	assign job_push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_tag_q    <= 1'b0;
			inside_entity_q <= 1'b0;
		end else if (accept) begin
			inside_tag_q    <= tag_d && !end_of_text;
			inside_entity_q <= entity_d && !end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			markup_en_q    <= 1'b0;
			tag_open_q     <= mes_pkg::RST_TAG_OPEN;
			tag_close_q    <= mes_pkg::RST_TAG_CLOSE;
			entity_start_q <= mes_pkg::RST_ENTITY_START;
		end else if (wr_en) begin
			case (wr_index)
				mes_pkg::REG_MARKUP_EN:    markup_en_q    <= wr_data[0];
				mes_pkg::REG_TAG_OPEN:     tag_open_q     <= wr_data;
				mes_pkg::REG_TAG_CLOSE:    tag_close_q    <= wr_data;
				mes_pkg::REG_ENTITY_START: entity_start_q <= wr_data;
				default: ;
			endcase
		end
	end

endmodule

@@ sv/mes_job_fifo.sv @@
`timescale 1ns / 1ps
// Short job queue between the front and back ends, built from flip-flops.
// Depends on mes_pkg for the job type.
module mes_job_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  mes_pkg::job_t wdata,
	output logic          full,
	input  logic          rd,
	output logic          rvalid,
	output mes_pkg::job_t rdata
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	mes_pkg::job_t      mem_q [DEPTH];
	logic [PTR_W-1:0]   wptr_q;
	logic [PTR_W-1:0]   rptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_wr;
	logic               do_rd;

	assign full   = count_q == CNT_W'(DEPTH);
	assign rvalid = count_q != '0;
	assign rdata  = mem_q[rptr_q];
	assign do_wr  = wr && !full;
	assign do_rd  = rd && rvalid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ sv/mes_back.sv @@
`timescale 1ns / 1ps
// Back end: expands each job into output bytes, one per cycle while the output is popped,
// into the result register. Depends on mes_pkg for the job type and the escape tables.
module mes_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	input  mes_pkg::job_t job,
	output logic          job_pop,
	output logic          empty,
	input  logic          pop,
	output logic [7:0]    out_byte,
	output logic          run_last
);

	logic                          out_valid_q;
	logic [7:0]                    out_byte_q;
	logic                          run_last_q;
	logic [mes_pkg::ESC_IDX_W-1:0] idx_q;
	logic                          out_ready;
	logic                          load;
	logic                          last;
	logic [7:0]                    next_byte;

	assign out_ready = !out_valid_q || pop;
	assign load      = out_ready && job_valid;
	assign last      = !job.esc || (idx_q == mes_pkg::esc_last_idx(job.ch));
	assign next_byte = job.esc ? mes_pkg::esc_byte(job.ch, idx_q) : job.ch;
	assign job_pop   = load && last;

	assign empty    = !out_valid_q;
	assign out_byte = out_byte_q;
	assign run_last = run_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (out_ready) begin
				out_valid_q <= job_valid;
			end
			if (load) begin
				idx_q <= last ? '0 : idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= next_byte;
			run_last_q <= last;
		end
	end

endmodule

@@ sv/markup_escape_stream.sv @@
`timescale 1ns / 1ps
// Top level of the markup escape stream converter. Instantiates mes_front,
// mes_job_fifo and mes_back; depends on mes_pkg.
//
// Use: source text enters one byte a beat on the push/full side, with end_of_text set
// on the last byte of a text. Converted bytes leave on the empty/pop side, one byte a
// beat, with run_last set on the final byte produced by each input byte. Input bytes
// that produce nothing leave no trace on the output side.
// Configuration is written through wr_en/wr_index/wr_data while the block is idle.
// The first output byte of an accepted input byte passes through the job queue and then
// the output register before it reaches the output ports.
// Throughput: one input byte per cycle while each yields one output byte and pop is held
// high. The back end emits one output byte per cycle while popped, so an escape sequence
// of four to six bytes holds it up; JOB_DEPTH queued jobs absorb this before full rises.
// Reset clears the region flags, loads the register defaults and empties the queue.
// When the receiver stops popping, the output byte holds, the queue fills and full
// then stalls the sender; no beat is lost.
module markup_escape_stream #(
	parameter int unsigned JOB_DEPTH = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [7:0]                    in_byte,
	input  logic                          end_of_text,
	output logic                          empty,
	input  logic                          pop,
	output logic [7:0]                    out_byte,
	output logic                          run_last,
	input  logic                          wr_en,
	input  logic [mes_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [7:0]                    wr_data
);

	logic          job_push;
	logic          job_full;
	mes_pkg::job_t job_in;
	logic          job_valid;
	logic          job_pop;
	mes_pkg::job_t job_head;

	mes_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.job_full    (job_full),
		.job_push    (job_push),
		.job         (job_in)
	);

	mes_job_fifo #(
		.DEPTH (JOB_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_push),
		.wdata  (job_in),
		.full   (job_full),
		.rd     (job_pop),
		.rvalid (job_valid),
		.rdata  (job_head)
	);

	mes_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job_head),
		.job_pop   (job_pop),
		.empty     (empty),
		.pop       (pop),
		.out_byte  (out_byte),
		.run_last  (run_last)
	);

endmodule

@@ sv/mes_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for markup_escape_stream and the bind that attaches it.
// Depends on mes_pkg for character codes.
module mes_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic [7:0] out_byte,
	input logic       run_last
);

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_byte) && $stable(run_last))
		else $error("output beat changed while stalled");

	a_full_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && !full))
		else $error("queue became full without an accepted beat");

	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("queue full while the output register is empty");

	a_escape_continues: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !run_last |=> !empty)
		else $error("escape sequence broken off");

	a_no_early_semicolon: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !run_last |-> out_byte != mes_pkg::CH_SEMI)
		else $error("semicolon inside an escape sequence");

endmodule

bind markup_escape_stream mes_checker u_mes_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.push     (push),
	.full     (full),
	.empty    (empty),
	.pop      (pop),
	.out_byte (out_byte),
	.run_last (run_last)
);

@@ tb/markup_escape_stream_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for markup_escape_stream: directed and random text through
// the push/full and empty/pop queues, checked beat by beat against a built-in predictor.
// Depends on mes_pkg and the markup_escape_stream RTL.
module markup_escape_stream_tb;

	typedef struct packed {
		logic [7:0] b;
		logic       last;
	} out_beat_t;

	class escape_scoreboard;
		logic       markup_en;
		logic [7:0] tag_open;
		logic [7:0] tag_close;
		logic [7:0] ent_start;
		logic       in_tag;
		logic       in_ent;
		logic [7:0] burst[$];
		out_beat_t  expected_q[$];
		int         errors;
		int         bytes_in;
		int         bytes_out;

		function new();
			markup_en = 1'b0;
			tag_open  = mes_pkg::RST_TAG_OPEN;
			tag_close = mes_pkg::RST_TAG_CLOSE;
			ent_start = mes_pkg::RST_ENTITY_START;
			in_tag    = 1'b0;
			in_ent    = 1'b0;
			errors    = 0;
			bytes_in  = 0;
			bytes_out = 0;
		endfunction

		function void set_reg(logic [mes_pkg::REG_IDX_W-1:0] idx, logic [7:0] d);
			case (idx)
				mes_pkg::REG_MARKUP_EN:    markup_en = d[0];
				mes_pkg::REG_TAG_OPEN:     tag_open  = d;
				mes_pkg::REG_TAG_CLOSE:    tag_close = d;
				mes_pkg::REG_ENTITY_START: ent_start = d;
				default: ;
			endcase
		endfunction

		function void add_text(string s);
			for (int k = 0; k < s.len(); k++)
				burst.push_back(s[k]);
		endfunction

		function void note_input(logic [7:0] c, logic eot);
			out_beat_t beat;
			burst.delete();
			bytes_in++;
			if (in_tag) begin
				if (c == tag_close) begin
					in_tag = 1'b0;
					if (markup_en)
						burst.push_back(mes_pkg::CH_GT);
				end else if (markup_en) begin
					burst.push_back(c);
				end
			end else if (in_ent) begin
				if (markup_en)
					burst.push_back(c);
				if (c == mes_pkg::CH_SEMI)
					in_ent = 1'b0;
			end else if (c == tag_open) begin
				in_tag = 1'b1;
				if (markup_en)
					burst.push_back(mes_pkg::CH_LT);
			end else if (c == tag_close) begin
				if (markup_en)
					burst.push_back(mes_pkg::CH_GT);
			end else if (c == ent_start) begin
				in_ent = 1'b1;
				if (markup_en)
					burst.push_back(mes_pkg::CH_AMP);
			end else if (markup_en) begin
				case (c)
					mes_pkg::CH_LT:   add_text("&lt;");
					mes_pkg::CH_GT:   add_text("&gt;");
					mes_pkg::CH_AMP:  add_text("&amp;");
					mes_pkg::CH_QUOT: add_text("&quot;");
					default: burst.push_back(c);
				endcase
			end else begin
				burst.push_back(c);
			end
			if (eot) begin
				in_tag = 1'b0;
				in_ent = 1'b0;
			end
			foreach (burst[i]) begin
				beat.b    = burst[i];
				beat.last = (i == burst.size() - 1);
				expected_q.push_back(beat);
			end
		endfunction

		function void check_output(logic [7:0] b, logic last);
			out_beat_t want;
			bytes_out++;
			if (expected_q.size() == 0) begin
				$error("unexpected output beat: out_byte %h run_last %b", b, last);
				errors++;
			end else begin
				want = expected_q.pop_front();
				if (b !== want.b) begin
					$error("out_byte: expected %h, got %h", want.b, b);
					errors++;
				end
				if (last !== want.last) begin
					$error("run_last: expected %b, got %b", want.last, last);
					errors++;
				end
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void finish_check();
			if (expected_q.size() != 0) begin
				$error("%0d expected output beats never arrived", expected_q.size());
				errors++;
			end
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          push = 1'b0;
	logic                          full;
	logic [7:0]                    in_byte = 8'h00;
	logic                          end_of_text = 1'b0;
	logic                          empty;
	logic                          pop = 1'b0;
	logic [7:0]                    out_byte;
	logic                          run_last;
	logic                          wr_en = 1'b0;
	logic [mes_pkg::REG_IDX_W-1:0] wr_index = mes_pkg::REG_MARKUP_EN;
	logic [7:0]                    wr_data = 8'h00;

	escape_scoreboard sb = new();

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int sent = 0;
	int settings_used = 0;
	int full_stalls = 0;

	markup_escape_stream i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.in_byte    (in_byte),
		.end_of_text(end_of_text),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_output(out_byte, run_last);
		if (hold_reqs != hold_seen) begin
			hold_seen = hold_reqs;
			hold_left = 150;
		end else if (hold_left > 0) begin
			hold_left--;
		end
		pop <= arst_n && hold_left == 0 && $urandom_range(0, 99) >= rx_stall_pct;
	end

	task automatic send_byte(logic [7:0] c, logic eot);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push        <= 1'b1;
		in_byte     <= c;
		end_of_text <= eot;
		@(posedge clk);
		while (full) begin
			full_stalls++;
			@(posedge clk);
		end
		sb.note_input(c, eot);
		sent++;
	endtask

	task automatic wait_idle(int max_cycles);
		int n;
		n = 0;
		push <= 1'b0;
		while (sb.pending() != 0 && n < max_cycles) begin
			@(posedge clk);
			n++;
		end
		repeat (10) @(posedge clk);
	endtask

	task automatic write_regs(logic en, logic [7:0] t_open, logic [7:0] t_close,
			logic [7:0] e_start);
		logic [7:0] vals[4];
		vals[0] = ($urandom_range(0, 255) & 8'hFE) | {7'd0, en};
		vals[1] = t_open;
		vals[2] = t_close;
		vals[3] = e_start;
		for (int k = 0; k < 4; k++) begin
			wr_en    <= 1'b1;
			wr_index <= mes_pkg::REG_IDX_W'(k);
			wr_data  <= vals[k];
			@(posedge clk);
			sb.set_reg(mes_pkg::REG_IDX_W'(k), vals[k]);
		end
		wr_en <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [7:0] pick_text();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return 8'($urandom_range(0, 255));
		else if (r < 8) begin
			case ($urandom_range(0, 4))
				0: return mes_pkg::CH_LT;
				1: return mes_pkg::CH_GT;
				2: return mes_pkg::CH_AMP;
				3: return mes_pkg::CH_QUOT;
				default: return mes_pkg::CH_SEMI;
			endcase
		end
		return 8'($urandom_range(8'h61, 8'h7A));
	endfunction

	function automatic logic pick_eot();
		return $urandom_range(0, 99) < 3;
	endfunction

	task automatic send_segment();
		int n;
		n = $urandom_range(1, 4);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				repeat (n) send_byte(pick_text(), pick_eot());
			end
			4, 5: begin
				send_byte(sb.tag_open, 1'b0);
				repeat (n - 1) send_byte(pick_text(), 1'b0);
				send_byte(sb.tag_close, pick_eot());
			end
			6, 7: begin
				send_byte(sb.ent_start, 1'b0);
				repeat (n) send_byte(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
				send_byte(mes_pkg::CH_SEMI, pick_eot());
			end
			8: begin
				repeat (n) begin
					case ($urandom_range(0, 3))
						0: send_byte(sb.tag_open, pick_eot());
						1: send_byte(sb.tag_close, pick_eot());
						2: send_byte(sb.ent_start, pick_eot());
						default: send_byte(8'($urandom_range(0, 255)), pick_eot());
					endcase
				end
			end
			default: begin
				send_byte($urandom_range(0, 1) ? sb.tag_open : sb.ent_start, 1'b0);
				repeat (n - 1) send_byte(pick_text(), 1'b0);
				send_byte(pick_text(), 1'b1);
			end
		endcase
	endtask

	logic [7:0] cfg_open[8];
	logic [7:0] cfg_close[8];
	logic [7:0] cfg_ent[8];
	logic       cfg_en[8];

	initial begin
		int target;
		bit paused;

		cfg_en[0] = 1'b1; cfg_open[0] = 8'd3;   cfg_close[0] = 8'd4;   cfg_ent[0] = 8'd6;
		cfg_en[1] = 1'b1; cfg_open[1] = 8'h10;  cfg_close[1] = 8'h11;  cfg_ent[1] = 8'h12;
		cfg_en[2] = 1'b0; cfg_open[2] = 8'hFF;  cfg_close[2] = 8'h00;  cfg_ent[2] = 8'h80;
		cfg_en[3] = 1'b1; cfg_open[3] = 8'h00;  cfg_close[3] = 8'hFF;
		cfg_ent[3] = mes_pkg::CH_AMP;
		cfg_en[4] = 1'b1; cfg_open[4] = mes_pkg::CH_LT; cfg_close[4] = mes_pkg::CH_LT;
		cfg_ent[4] = mes_pkg::CH_LT;
		cfg_en[5] = 1'b1; cfg_open[5] = 8'hAA;  cfg_close[5] = 8'h55;  cfg_ent[5] = 8'hAA;
		cfg_en[6] = 1'b0;
		cfg_open[6] = 8'($urandom_range(0, 255));
		cfg_close[6] = 8'($urandom_range(0, 255));
		cfg_ent[6] = 8'($urandom_range(0, 255));
		cfg_en[7] = 1'b1; cfg_open[7] = mes_pkg::CH_QUOT; cfg_close[7] = mes_pkg::CH_SEMI;
		cfg_ent[7] = mes_pkg::CH_GT;
		cfg_open[1] = 8'($urandom_range(8'h80, 8'hFF));
		cfg_close[1] = 8'($urandom_range(8'h01, 8'h1F));
		cfg_ent[1] = 8'($urandom_range(8'h30, 8'h39));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: markup stripped, markers 3, 4 and 6.
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'd3, 1'b0);
		send_byte(8'd6, 1'b0);
		send_byte(8'd4, 1'b0);
		send_byte(mes_pkg::CH_QUOT, 1'b0);
		send_byte(8'd6, 1'b0);
		send_byte(8'h62, 1'b0);
		send_byte(mes_pkg::CH_SEMI, 1'b0);
		send_byte(8'd4, 1'b1);
		wait_idle(20000);

		write_regs(1'b1, mes_pkg::RST_TAG_OPEN, mes_pkg::RST_TAG_CLOSE,
			mes_pkg::RST_ENTITY_START);
		send_byte(mes_pkg::CH_LT, 1'b0);
		send_byte(mes_pkg::CH_GT, 1'b0);
		send_byte(mes_pkg::CH_AMP, 1'b0);
		send_byte(mes_pkg::CH_QUOT, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'd4, 1'b0);
		send_byte(8'd3, 1'b0);
		send_byte(mes_pkg::CH_AMP, 1'b0);
		send_byte(8'd6, 1'b0);
		send_byte(8'd4, 1'b0);
		send_byte(8'd6, 1'b0);
		send_byte(mes_pkg::CH_LT, 1'b0);
		send_byte(mes_pkg::CH_SEMI, 1'b0);
		send_byte(8'd3, 1'b0);
		send_byte(8'h71, 1'b1);
		send_byte(mes_pkg::CH_LT, 1'b0);

		for (int ph = 0; ph < 8; ph++) begin
			wait_idle(20000);
			write_regs(cfg_en[ph], cfg_open[ph], cfg_close[ph], cfg_ent[ph]);
			case (ph % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 86; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 86; end
				default: begin tx_idle_pct = 31; rx_stall_pct = 31; end
			endcase
			// The receiver goes quiet for a long stretch while text keeps coming.
			if (ph == 4)
				hold_reqs <= hold_reqs + 1;
			paused = 0;
			target = sent + 22;
			while (sent < target) begin
				send_segment();
				if (ph == 5 && !paused && sent >= target - 14) begin
					wait_idle(20000);
					paused = 1;
				end
			end
		end

		wait_idle(20000);
		sb.finish_check();
		$display("Sent %0d input bytes and checked %0d output beats over %0d register settings.",
			sb.bytes_in, sb.bytes_out, settings_used);
		$display("The sender was held back by full on %0d cycles.", full_stalls);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
